// ===== rtl/core/rvdec_pkg.sv =====
// ----------------------------------------------------------------------------
// RV32 decode package
// Shared field widths, format and ALU codes, opcodes and the word types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rvdec_pkg;

   localparam int XLEN        = 32;
   localparam int REG_IDX_W   = 5;
   localparam int NUM_REGS_DEF = 32;

   // Instruction format codes.
   localparam logic [2:0] FMT_R   = 3'd0;
   localparam logic [2:0] FMT_I   = 3'd1;
   localparam logic [2:0] FMT_S   = 3'd2;
   localparam logic [2:0] FMT_B   = 3'd3;
   localparam logic [2:0] FMT_U   = 3'd4;
   localparam logic [2:0] FMT_J   = 3'd5;
   localparam logic [2:0] FMT_BAD = 3'd6;

   // ALU operation codes.
   localparam logic [3:0] ALU_NOP  = 4'd0;
   localparam logic [3:0] ALU_ADD  = 4'd1;
   localparam logic [3:0] ALU_SUB  = 4'd2;
   localparam logic [3:0] ALU_MUL  = 4'd3;
   localparam logic [3:0] ALU_SLL  = 4'd4;
   localparam logic [3:0] ALU_SLT  = 4'd5;
   localparam logic [3:0] ALU_SLTU = 4'd6;
   localparam logic [3:0] ALU_XOR  = 4'd7;
   localparam logic [3:0] ALU_SRL  = 4'd8;
   localparam logic [3:0] ALU_SRA  = 4'd9;
   localparam logic [3:0] ALU_OR   = 4'd10;
   localparam logic [3:0] ALU_AND  = 4'd11;

   // Major opcodes.
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_OP_IMM = 7'h13;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6F;

   // funct7 codes.
   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;
   localparam logic [6:0] F7_MULDIV = 7'h01;

   // Item opcodes.
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   typedef struct packed {
      logic                 op;
      logic [XLEN-1:0]      instruction;
      logic [REG_IDX_W-1:0] write_index;
      logic [XLEN-1:0]      write_value;
   } req_type;

   typedef struct packed {
      logic [2:0]           format_type;
      logic [REG_IDX_W-1:0] dest_reg;
      logic [REG_IDX_W-1:0] src1_reg;
      logic [REG_IDX_W-1:0] src2_reg;
      logic [2:0]           func3;
      logic [6:0]           func7;
      logic [3:0]           alu_select;
      logic [XLEN-1:0]      left_operand;
      logic [XLEN-1:0]      right_operand;
      logic [XLEN-1:0]      imm_value;
   } rsp_type;

   // Decoded instruction, passed from the decoder to the operand stage.
   typedef struct packed {
      logic [2:0]           fmt;
      logic [REG_IDX_W-1:0] rd;
      logic [REG_IDX_W-1:0] rs1;
      logic [REG_IDX_W-1:0] rs2;
      logic [2:0]           f3;
      logic [6:0]           f7;
      logic [3:0]           alu;
      logic [XLEN-1:0]      imm;
      logic [REG_IDX_W-1:0] rd_a_idx;
      logic [REG_IDX_W-1:0] rd_b_idx;
      logic                 use_left;
      logic                 use_right_reg;
      logic                 use_right_imm;
   } dec_type;

endpackage

`default_nettype wire

// ===== rtl/core/rv32_decode_with_regfile_read_top.sv =====
// ----------------------------------------------------------------------------
// RV32 decode stage with register file read
// An accepted decode word goes through the stage-one registers and then the
// output register. Throughput: one word per cycle while rsp is not stalled.
// Write words update the register file at the edge they are accepted and give
// no result. Reset (synchronous, active high) clears all registers to zero at
// once through valid bits and empties the pipeline; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rv32_decode_with_regfile_read_top
   import rvdec_pkg::*;
#(
   parameter int NUM_REGS = NUM_REGS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   // The pipeline has two stages. At the accept edge the instruction is
   // decoded and the register file is read; the read data lands in the
   // memory's output registers alongside the decoded fields in stage one.
   // Once the output register is free, the operands are selected and the
   // finished word is loaded into the output register, which decouples the two channels.
   //
   // A write word goes straight into the memory at its accept edge. Since the
   // read for a decode word happens at that word's own accept edge, every
   // decode sees exactly the writes accepted before it, with no forwarding.

   dec_type         dec;
   dec_type         s1_dec_ff;
   logic            s1_valid_ff, s1_valid_in;
   logic            out_valid_ff, out_valid_in;
   rsp_type         out_ff, out_in;
   logic            out_free, s1_move, accept, dec_accept, wr_accept;
   logic [XLEN-1:0] rd_a_data, rd_b_data;

   rvdec_decode u_decode (
      .instruction (req_data.instruction),
      .dec         (dec)
   );

   rvdec_regfile #(
      .NUM_REGS (NUM_REGS)
   ) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_accept),
      .wr_idx    (req_data.write_index),
      .wr_data   (req_data.write_value),
      .rd_en     (dec_accept),
      .rd_a_idx  (dec.rd_a_idx),
      .rd_b_idx  (dec.rd_b_idx),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   // The output register can take a new word when it is empty or its word
   // is leaving this cycle. Else a full stage one holds and the input stalls;
   // that also keeps the memory read data steady while stage one waits.
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign accept     = req_valid && !req_stall;
   assign dec_accept = accept && (req_data.op == OP_DECODE);
   assign wr_accept  = accept && (req_data.op == OP_WRITE);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (dec_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = s1_valid_ff;
      end

      // Operand selection from the registered reads.
      out_in.format_type   = s1_dec_ff.fmt;
      out_in.dest_reg      = s1_dec_ff.rd;
      out_in.src1_reg      = s1_dec_ff.rs1;
      out_in.src2_reg      = s1_dec_ff.rs2;
      out_in.func3         = s1_dec_ff.f3;
      out_in.func7         = s1_dec_ff.f7;
      out_in.alu_select    = s1_dec_ff.alu;
      out_in.imm_value     = s1_dec_ff.imm;
      out_in.left_operand  = s1_dec_ff.use_left ? rd_a_data : '0;
      if (s1_dec_ff.use_right_reg) begin
         out_in.right_operand = rd_b_data;
      end else if (s1_dec_ff.use_right_imm) begin
         out_in.right_operand = s1_dec_ff.imm;
      end else begin
         out_in.right_operand = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dec_accept) begin
         s1_dec_ff <= dec;
      end
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rvdec_regfile.sv =====
// ----------------------------------------------------------------------------
// RV32 register file
// One write port and two registered read ports; per-entry valid bits give
// the cleared state after reset. Register zero and indexes beyond the depth
// read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rvdec_regfile
   import rvdec_pkg::*;
#(
   parameter int NUM_REGS = NUM_REGS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_en,
   input  wire logic [REG_IDX_W-1:0] wr_idx,
   input  wire logic [XLEN-1:0]      wr_data,
   input  wire logic                 rd_en,
   input  wire logic [REG_IDX_W-1:0] rd_a_idx,
   input  wire logic [REG_IDX_W-1:0] rd_b_idx,
   output logic      [XLEN-1:0]      rd_a_data,
   output logic      [XLEN-1:0]      rd_b_data
);

   localparam int IDX_W = $clog2(NUM_REGS);

   logic [XLEN-1:0]     mem_ff [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff, valid_in;
   logic [XLEN-1:0]     data_a_ff, data_b_ff;
   logic                hit_a_ff, hit_a_in, hit_b_ff, hit_b_in;
   logic                wr_ok;

   function automatic logic idx_live(input logic [REG_IDX_W-1:0] idx);
      return (idx != '0) &&
             ((REG_IDX_W+1)'(idx) < (REG_IDX_W+1)'(NUM_REGS));
   endfunction

   assign wr_ok = wr_en && idx_live(wr_idx);

   always_comb begin
      valid_in = valid_ff;
      if (wr_ok) begin
         valid_in[wr_idx[IDX_W-1:0]] = 1'b1;
      end
      hit_a_in = idx_live(rd_a_idx) && valid_ff[rd_a_idx[IDX_W-1:0]];
      hit_b_in = idx_live(rd_b_idx) && valid_ff[rd_b_idx[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_a_ff <= 1'b0;
         hit_b_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            hit_a_ff <= hit_a_in;
            hit_b_ff <= hit_b_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem_ff[wr_idx[IDX_W-1:0]] <= wr_data;
      end
      if (rd_en) begin
         data_a_ff <= mem_ff[rd_a_idx[IDX_W-1:0]];
         data_b_ff <= mem_ff[rd_b_idx[IDX_W-1:0]];
      end
   end

   assign rd_a_data = hit_a_ff ? data_a_ff : '0;
   assign rd_b_data = hit_b_ff ? data_b_ff : '0;

endmodule

`default_nettype wire

// ===== rtl/core/rvdec_decode.sv =====
// ----------------------------------------------------------------------------
// RV32 instruction decoder
// Classifies the opcode, extracts fields, builds the immediate, picks the ALU
// operation and chooses which register reads feed the operands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rvdec_decode
   import rvdec_pkg::*;
(
   input  wire logic [XLEN-1:0] instruction,
   output dec_type              dec
);

   logic [6:0]           opc, top7;
   logic [2:0]           ri3;
   logic [REG_IDX_W-1:0] ri7, ri1, ri2;
   logic [XLEN-1:0]      imm_i, imm_s, imm_b, imm_u, imm_j;
   logic [3:0]           alu_r, alu_i;

   assign opc  = instruction[6:0];
   assign ri7  = instruction[11:7];
   assign ri3  = instruction[14:12];
   assign ri1  = instruction[19:15];
   assign ri2  = instruction[24:20];
   assign top7 = instruction[31:25];

   assign imm_i = {{20{instruction[31]}}, instruction[31:20]};
   assign imm_s = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
   assign imm_b = {{19{instruction[31]}}, instruction[31], instruction[7],
                   instruction[30:25], instruction[11:8], 1'b0};
   assign imm_u = {instruction[31:12], 12'b0};
   assign imm_j = {{11{instruction[31]}}, instruction[31], instruction[19:12],
                   instruction[20], instruction[30:21], 1'b0};

   always_comb begin
      case (ri3)
         3'd0: begin
            if (top7 == F7_BASE) begin
               alu_r = ALU_ADD;
            end else if (top7 == F7_ALT) begin
               alu_r = ALU_SUB;
            end else if (top7 == F7_MULDIV) begin
               alu_r = ALU_MUL;
            end else begin
               alu_r = ALU_NOP;
            end
         end
         3'd1: alu_r = ALU_SLL;
         3'd2: alu_r = ALU_SLT;
         3'd3: alu_r = ALU_SLTU;
         3'd4: alu_r = ALU_XOR;
         3'd5: alu_r = (top7 == F7_BASE) ? ALU_SRL : ALU_SRA;
         3'd6: alu_r = ALU_OR;
         default: alu_r = ALU_AND;
      endcase

      case (ri3)
         3'd0: alu_i = ALU_ADD;
         3'd1: alu_i = ALU_SLL;
         3'd2: alu_i = ALU_SLT;
         3'd3: alu_i = ALU_SLTU;
         3'd4: alu_i = ALU_XOR;
         3'd5: alu_i = (top7 == F7_ALT) ? ALU_SRA : ALU_SRL;
         3'd6: alu_i = ALU_OR;
         default: alu_i = ALU_AND;
      endcase
   end

   always_comb begin
      dec          = '0;
      dec.fmt      = FMT_BAD;
      dec.alu      = ALU_NOP;
      dec.rd_a_idx = ri1;
      dec.rd_b_idx = ri2;
      case (opc)
         OPC_OP: begin
            dec.fmt           = FMT_R;
            dec.rd            = ri7;
            dec.rs1           = ri1;
            dec.rs2           = ri2;
            dec.f3            = ri3;
            dec.f7            = top7;
            dec.alu           = alu_r;
            dec.use_left      = 1'b1;
            dec.use_right_reg = 1'b1;
         end
         OPC_OP_IMM, OPC_LOAD, OPC_JALR, OPC_SYSTEM: begin
            dec.fmt           = FMT_I;
            dec.rd            = ri7;
            dec.rs1           = ri1;
            dec.f3            = ri3;
            dec.alu           = alu_i;
            dec.imm           = imm_i;
            dec.use_left      = 1'b1;
            dec.use_right_imm = 1'b1;
         end
         OPC_STORE: begin
            // The store data comes out on the left operand.
            dec.fmt           = FMT_S;
            dec.rs1           = ri1;
            dec.rs2           = ri2;
            dec.f3            = ri3;
            dec.alu           = ALU_ADD;
            dec.imm           = imm_s;
            dec.rd_a_idx      = ri2;
            dec.use_left      = 1'b1;
            dec.use_right_imm = 1'b1;
         end
         OPC_BRANCH: begin
            dec.fmt           = FMT_B;
            dec.rs1           = ri1;
            dec.rs2           = ri2;
            dec.f3            = ri3;
            dec.alu           = ALU_SUB;
            dec.imm           = imm_b;
            dec.use_left      = 1'b1;
            dec.use_right_reg = 1'b1;
         end
         OPC_LUI, OPC_AUIPC: begin
            dec.fmt           = FMT_U;
            dec.rd            = ri7;
            dec.alu           = ALU_ADD;
            dec.imm           = imm_u;
            dec.use_right_imm = 1'b1;
         end
         OPC_JAL: begin
            dec.fmt           = FMT_J;
            dec.rd            = ri7;
            dec.alu           = ALU_ADD;
            dec.imm           = imm_j;
            dec.use_right_imm = 1'b1;
         end
         default: begin
            dec.fmt = FMT_BAD;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for the RV32 decode stage with register file read
// Drives register write words and instruction decode words through the
// valid/stall request channel and checks every decode result against its
// script's typed-in result or an in-bench predictor with its own register file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import rvdec_pkg::*;

   // Traffic shapes for the sender and the receiver.
   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_SEND_IDLE,
      MODE_RECV_STALL,
      MODE_BOTH
   } traffic_mode_type;

   // funct3 values as they appear in the instruction word.
   localparam logic [2:0] F3_ADD         = 3'd0;
   localparam logic [2:0] F3_SLL         = 3'd1;
   localparam logic [2:0] F3_SLT         = 3'd2;
   localparam logic [2:0] F3_SLTU        = 3'd3;
   localparam logic [2:0] F3_XOR         = 3'd4;
   localparam logic [2:0] F3_SHIFT_RIGHT = 3'd5;
   localparam logic [2:0] F3_OR          = 3'd6;
   localparam logic [2:0] F3_AND         = 3'd7;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 8;
   localparam int REPORT_LIMIT   = 10;

   // One row of the directed script. When the expected result is typed in,
   // it replaces the predictor's answer for that word.
   typedef struct {
      req_type word;
      bit      typed_in;
      rsp_type want;
   } script_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Side band that travels with each offered word: a typed-in expectation.
   logic    typed_valid = 1'b0;
   rsp_type typed_want  = '0;

   traffic_mode_type traffic_mode = MODE_NONE;
   bit               hold_request = 1'b0;

   logic [XLEN-1:0] shadow_regs [NUM_REGS_DEF];
   rsp_type         expected_decodes [$];
   script_row_type  script [$];

   int error_count     = 0;
   int mismatch_count  = 0;
   int write_count     = 0;
   int decode_count    = 0;
   int results_checked = 0;

   rv32_decode_with_regfile_read_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 20 ns clock period.
   initial begin
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Register zero, and any index past the implemented file, read as zero.
   function automatic logic [XLEN-1:0] read_shadow(input logic [REG_IDX_W-1:0] idx);
      if (idx == '0 || idx >= NUM_REGS_DEF) begin
         return '0;
      end
      return shadow_regs[idx];
   endfunction

   // ALU choice. For R words funct7 picks among add, sub and mul, and splits
   // the right shifts. For I words only the top seven bits equal to the
   // alternate code turn a right shift into an arithmetic one.
   function automatic logic [3:0] alu_for(input bit r_word, input logic [2:0] f3,
                                          input logic [6:0] f7);
      case (f3)
         F3_ADD: begin
            if (!r_word || f7 == F7_BASE) return ALU_ADD;
            if (f7 == F7_ALT) return ALU_SUB;
            if (f7 == F7_MULDIV) return ALU_MUL;
            return ALU_NOP;
         end
         F3_SLL:  return ALU_SLL;
         F3_SLT:  return ALU_SLT;
         F3_SLTU: return ALU_SLTU;
         F3_XOR:  return ALU_XOR;
         F3_SHIFT_RIGHT: begin
            if (r_word) return (f7 == F7_BASE) ? ALU_SRL : ALU_SRA;
            return (f7 == F7_ALT) ? ALU_SRA : ALU_SRL;
         end
         F3_OR:   return ALU_OR;
         default: return ALU_AND;
      endcase
   endfunction

   // Works out the full decode result of one instruction word against the
   // current shadow register file. Fields a format lacks stay zero.
   function automatic rsp_type predict_decode(input logic [XLEN-1:0] insn);
      rsp_type                r;
      logic [6:0]             opcode;
      logic [6:0]             top7;
      logic [2:0]             f3;
      logic [REG_IDX_W-1:0]   rd;
      logic [REG_IDX_W-1:0]   rs1;
      logic [REG_IDX_W-1:0]   rs2;
      r           = '0;
      r.format_type = FMT_BAD;
      r.alu_select  = ALU_NOP;
      opcode = insn[6:0];
      rd     = insn[11:7];
      f3     = insn[14:12];
      rs1    = insn[19:15];
      rs2    = insn[24:20];
      top7   = insn[31:25];
      case (opcode)
         OPC_OP: begin
            r.format_type   = FMT_R;
            r.dest_reg      = rd;
            r.src1_reg      = rs1;
            r.src2_reg      = rs2;
            r.func3         = f3;
            r.func7         = top7;
            r.alu_select    = alu_for(1'b1, f3, top7);
            r.left_operand  = read_shadow(rs1);
            r.right_operand = read_shadow(rs2);
         end
         OPC_OP_IMM, OPC_LOAD, OPC_JALR, OPC_SYSTEM: begin
            r.format_type   = FMT_I;
            r.dest_reg      = rd;
            r.src1_reg      = rs1;
            r.func3         = f3;
            r.imm_value     = {{20{insn[31]}}, insn[31:20]};
            r.alu_select    = alu_for(1'b0, f3, top7);
            r.left_operand  = read_shadow(rs1);
            r.right_operand = r.imm_value;
         end
         OPC_STORE: begin
            // The store data register goes out on the left operand.
            r.format_type   = FMT_S;
            r.src1_reg      = rs1;
            r.src2_reg      = rs2;
            r.func3         = f3;
            r.imm_value     = {{20{insn[31]}}, insn[31:25], insn[11:7]};
            r.alu_select    = ALU_ADD;
            r.left_operand  = read_shadow(rs2);
            r.right_operand = r.imm_value;
         end
         OPC_BRANCH: begin
            r.format_type   = FMT_B;
            r.src1_reg      = rs1;
            r.src2_reg      = rs2;
            r.func3         = f3;
            r.imm_value     = {{19{insn[31]}}, insn[31], insn[7], insn[30:25],
                               insn[11:8], 1'b0};
            r.alu_select    = ALU_SUB;
            r.left_operand  = read_shadow(rs1);
            r.right_operand = read_shadow(rs2);
         end
         OPC_LUI, OPC_AUIPC: begin
            r.format_type   = FMT_U;
            r.dest_reg      = rd;
            r.imm_value     = {insn[31:12], 12'd0};
            r.alu_select    = ALU_ADD;
            r.right_operand = r.imm_value;
         end
         OPC_JAL: begin
            r.format_type   = FMT_J;
            r.dest_reg      = rd;
            r.imm_value     = {{11{insn[31]}}, insn[31], insn[19:12], insn[20],
                               insn[30:21], 1'b0};
            r.alu_select    = ALU_ADD;
            r.right_operand = r.imm_value;
         end
         default: ;
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Word builders and the directed script
   // ------------------------------------------------------------------------

   function automatic req_type decode_req(input logic [XLEN-1:0] insn);
      req_type w;
      w             = '0;
      w.op          = OP_DECODE;
      w.instruction = insn;
      return w;
   endfunction

   function automatic req_type write_req(input logic [REG_IDX_W-1:0] idx,
                                         input logic [XLEN-1:0] value);
      req_type w;
      w             = '0;
      w.op          = OP_WRITE;
      w.write_index = idx;
      w.write_value = value;
      return w;
   endfunction

   function automatic rsp_type typed(input logic [2:0] fmt, input logic [4:0] rd,
                                     input logic [4:0] rs1, input logic [4:0] rs2,
                                     input logic [2:0] f3, input logic [6:0] f7,
                                     input logic [3:0] alu, input logic [31:0] left,
                                     input logic [31:0] right, input logic [31:0] imm);
      rsp_type r;
      r.format_type   = fmt;
      r.dest_reg      = rd;
      r.src1_reg      = rs1;
      r.src2_reg      = rs2;
      r.func3         = f3;
      r.func7         = f7;
      r.alu_select    = alu;
      r.left_operand  = left;
      r.right_operand = right;
      r.imm_value     = imm;
      return r;
   endfunction

   function automatic void add_row(input req_type word, input bit typed_in,
                                   input rsp_type want);
      script_row_type row;
      row.word     = word;
      row.typed_in = typed_in;
      row.want     = want;
      script.push_back(row);
   endfunction

   // Random word: a quarter are register writes, the rest decodes. Most
   // decodes carry a supported opcode with random fields, and some force
   // the funct7 values that steer the ALU choice.
   function automatic req_type random_word();
      req_type w;
      w.op          = ($urandom_range(99) < 25) ? OP_WRITE : OP_DECODE;
      w.instruction = $urandom;
      w.write_index = REG_IDX_W'($urandom);
      w.write_value = $urandom;
      if (w.op == OP_DECODE && $urandom_range(99) >= 8) begin
         case ($urandom_range(9))
            0:       w.instruction[6:0] = OPC_OP;
            1:       w.instruction[6:0] = OPC_OP_IMM;
            2:       w.instruction[6:0] = OPC_LOAD;
            3:       w.instruction[6:0] = OPC_JALR;
            4:       w.instruction[6:0] = OPC_SYSTEM;
            5:       w.instruction[6:0] = OPC_STORE;
            6:       w.instruction[6:0] = OPC_BRANCH;
            7:       w.instruction[6:0] = OPC_LUI;
            8:       w.instruction[6:0] = OPC_AUIPC;
            default: w.instruction[6:0] = OPC_JAL;
         endcase
         case ($urandom_range(5))
            0:       w.instruction[31:25] = F7_BASE;
            1:       w.instruction[31:25] = F7_ALT;
            2:       w.instruction[31:25] = F7_MULDIV;
            default: ;
         endcase
      end
      return w;
   endfunction

   // ------------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------------

   // Offers one word at the falling edge, after an optional idle gap whose
   // length follows the current traffic mode, and returns at the rising edge
   // that accepts it. The payload is held while the block stalls.
   task automatic offer_word(input req_type word, input bit typed_in,
                             input rsp_type want);
      int gap_pct;
      gap_pct = (traffic_mode == MODE_SEND_IDLE) ? 86 :
                (traffic_mode == MODE_BOTH)      ? 6  : 0;
      while ($urandom_range(99) < gap_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_data    <= word;
      typed_valid <= typed_in;
      typed_want  <= want;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic run_phase(input traffic_mode_type mode, input int count,
                            input bit with_hold);
      traffic_mode = mode;
      if (with_hold) begin
         hold_request = 1'b1;
      end
      repeat (count) begin
         offer_word(random_word(), 1'b0, '0);
      end
   endtask

   // ------------------------------------------------------------------------
   // Receiver
   // ------------------------------------------------------------------------

   // Stall is redrawn every falling edge from the traffic mode. A hold-off
   // request makes the receiver stall solidly until its hold-off counter runs out,
   // so the pipeline backs up and pushes stall onto the request side.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (traffic_mode)
               MODE_RECV_STALL: rsp_stall <= ($urandom_range(99) < 86);
               MODE_BOTH:       rsp_stall <= ($urandom_range(99) < 6);
               default:         rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Scoreboard
   // ------------------------------------------------------------------------

   function automatic void note_mismatch(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      error_count++;
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("Result %0d: %s expected %h, got %h", results_checked, field,
                  want, got);
      end
   endfunction

   // At every rising edge the result side is checked first, then an accepted
   // request word updates the shadow file or queues its expected result.
   // Results pass through the stage-one and output registers, so a word queued
   // at this edge can never be the one being checked at the same edge.
   always @(posedge clock) begin : scoreboard
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (expected_decodes.size() == 0) begin
               error_count++;
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("Result %0d arrived with nothing expected: %h",
                           results_checked, rsp_data);
               end
            end else begin
               want = expected_decodes.pop_front();
               if (rsp_data.format_type != want.format_type)
                  note_mismatch("format_type", want.format_type, rsp_data.format_type);
               if (rsp_data.dest_reg != want.dest_reg)
                  note_mismatch("dest_reg", want.dest_reg, rsp_data.dest_reg);
               if (rsp_data.src1_reg != want.src1_reg)
                  note_mismatch("src1_reg", want.src1_reg, rsp_data.src1_reg);
               if (rsp_data.src2_reg != want.src2_reg)
                  note_mismatch("src2_reg", want.src2_reg, rsp_data.src2_reg);
               if (rsp_data.func3 != want.func3)
                  note_mismatch("func3", want.func3, rsp_data.func3);
               if (rsp_data.func7 != want.func7)
                  note_mismatch("func7", want.func7, rsp_data.func7);
               if (rsp_data.alu_select != want.alu_select)
                  note_mismatch("alu_select", want.alu_select, rsp_data.alu_select);
               if (rsp_data.left_operand != want.left_operand)
                  note_mismatch("left_operand", want.left_operand,
                                rsp_data.left_operand);
               if (rsp_data.right_operand != want.right_operand)
                  note_mismatch("right_operand", want.right_operand,
                                rsp_data.right_operand);
               if (rsp_data.imm_value != want.imm_value)
                  note_mismatch("imm_value", want.imm_value, rsp_data.imm_value);
            end
         end
         if (req_valid && !req_stall) begin
            if (req_data.op == OP_WRITE) begin
               // Writes to register zero are dropped.
               write_count++;
               if (req_data.write_index != '0 && req_data.write_index < NUM_REGS_DEF) begin
                  shadow_regs[req_data.write_index] = req_data.write_value;
               end
            end else begin
               decode_count++;
               expected_decodes.push_back(typed_valid ? typed_want
                                          : predict_decode(req_data.instruction));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------------

   // Ends the run once no word has moved on either channel for a long time.
   // The limit is far above the receiver hold-off and any random stall run.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Timeout: no word moved for %0d cycles, %0d results still due",
               WATCHDOG_LIMIT, expected_decodes.size());
      $display("Some tests failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------

   initial begin : main
      for (int i = 0; i < NUM_REGS_DEF; i++) begin
         shadow_regs[i] = '0;
      end

      // Directed script. Right after reset every register is zero, so the
      // extreme words below have results that can be written down directly.
      // Register, funct7 and ALU corner cases later on go through the predictor.
      add_row(decode_req(32'h002081B3), 1'b1,                      // add x3,x1,x2
              typed(FMT_R, 3, 1, 2, 0, 0, ALU_ADD, 0, 0, 0));
      add_row(decode_req(32'h00000000), 1'b1,                      // unsupported, all zero
              typed(FMT_BAD, 0, 0, 0, 0, 0, ALU_NOP, 0, 0, 0));
      add_row(decode_req(32'hFFFFFFFF), 1'b1,                      // unsupported, all ones
              typed(FMT_BAD, 0, 0, 0, 0, 0, ALU_NOP, 0, 0, 0));
      add_row(decode_req(32'hFFFFFFB3), 1'b1,                      // R with every field full
              typed(FMT_R, 31, 31, 31, 7, 7'h7F, ALU_AND, 0, 0, 0));
      add_row(decode_req(32'hFFF00013), 1'b1,                      // addi x0,x0,-1
              typed(FMT_I, 0, 0, 0, 0, 0, ALU_ADD, 0, 32'hFFFFFFFF, 32'hFFFFFFFF));
      add_row(decode_req(32'hFFFFFF93), 1'b1,                      // andi, all fields full
              typed(FMT_I, 31, 31, 0, 7, 0, ALU_AND, 0, 32'hFFFFFFFF, 32'hFFFFFFFF));
      add_row(decode_req(32'hFFFFFFA3), 1'b1,                      // store, offset -1
              typed(FMT_S, 0, 31, 31, 7, 0, ALU_ADD, 0, 32'hFFFFFFFF, 32'hFFFFFFFF));
      add_row(decode_req(32'hFFFFFFE3), 1'b1,                      // branch, offset -2
              typed(FMT_B, 0, 31, 31, 7, 0, ALU_SUB, 0, 0, 32'hFFFFFFFE));
      add_row(decode_req(32'hFFFFF037), 1'b1,                      // lui with top bits set
              typed(FMT_U, 0, 0, 0, 0, 0, ALU_ADD, 0, 32'hFFFFF000, 32'hFFFFF000));
      add_row(decode_req(32'hFFFFFFEF), 1'b1,                      // jal x31, offset -2
              typed(FMT_J, 31, 0, 0, 0, 0, ALU_ADD, 0, 32'hFFFFFFFE, 32'hFFFFFFFE));
      // A write to register zero must not stick.
      add_row(write_req(5'd0, 32'hFFFFFFFF), 1'b0, '0);
      add_row(decode_req(32'h00000033), 1'b1,
              typed(FMT_R, 0, 0, 0, 0, 0, ALU_ADD, 0, 0, 0));
      add_row(write_req(5'd31, 32'hFFFFFFFF), 1'b0, '0);
      add_row(write_req(5'd1, 32'h80000000), 1'b0, '0);
      add_row(write_req(5'd2, 32'h00000001), 1'b0, '0);
      add_row(decode_req(32'h41F082B3), 1'b0, '0);                 // sub x5,x1,x31
      add_row(decode_req(32'h02110333), 1'b0, '0);                 // mul x6,x2,x1
      add_row(decode_req(32'hFE208033), 1'b0, '0);                 // funct3 0, odd funct7
      add_row(decode_req(32'h0020D1B3), 1'b0, '0);                 // srl
      add_row(decode_req(32'h4020D1B3), 1'b0, '0);                 // sra
      add_row(decode_req(32'h0220D1B3), 1'b0, '0);                 // right shift, funct7 one
      add_row(decode_req(32'h4010D193), 1'b0, '0);                 // srai
      add_row(decode_req(32'h4000D073), 1'b0, '0);                 // system word, shift bits
      add_row(decode_req(32'hFFF0A213), 1'b0, '0);                 // slti
      add_row(decode_req(32'h0010B293), 1'b0, '0);                 // sltiu
      add_row(decode_req(32'h01F08063), 1'b0, '0);                 // beq x1,x31
      add_row(decode_req(32'h80000017), 1'b0, '0);                 // auipc

      // Synchronous reset is held across rising edges and released on a falling one.
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      traffic_mode = MODE_NONE;
      foreach (script[i]) begin
         offer_word(script[i].word, script[i].typed_in, script[i].want);
      end

      // Random phases: back to back, a sparse sender, a sticky receiver,
      // light idling on both sides, and finally a long receiver hold-off
      // while the sender keeps pushing.
      run_phase(MODE_NONE,       500, 1'b0);
      run_phase(MODE_SEND_IDLE,  350, 1'b0);
      run_phase(MODE_RECV_STALL, 350, 1'b0);
      run_phase(MODE_BOTH,       425, 1'b0);
      run_phase(MODE_NONE,       300, 1'b1);

      @(negedge clock);
      req_valid    <= 1'b0;
      traffic_mode = MODE_NONE;

      // Drain, then keep clocking so the pipeline can show any stray result
      // before the verdict.
      while (expected_decodes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      error_count += expected_decodes.size();

      $display("Covered %0d register writes and %0d decodes, %0d results compared,",
               write_count, decode_count, results_checked);
      $display("under idle, stall, mixed and %0d-cycle hold-off traffic; %0d errors.",
               HOLD_CYCLES, error_count);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
